[rtl/trpfa_pkg.sv]
// Shared constants and types for the two-region page frame allocator.
// No dependencies; the core, the checker and the testbench import this package.
`default_nettype none
package trpfa_pkg;

	localparam int KERN_DEPTH = 1024;
	localparam int USER_PAGES = 4096;
	localparam int PAGE_BYTES = 4096;

	localparam int ADDR_W     = 56;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int FRAME_W    = ADDR_W - PAGE_SHIFT;
	localparam int FIRST_W    = FRAME_W + 1;
	localparam int DIFF_W     = FIRST_W + 1;

	localparam int KERN_IDX_W = $clog2(KERN_DEPTH);
	localparam int USER_IDX_W = $clog2(USER_PAGES);
	localparam int KERN_CNT_W = $clog2(KERN_DEPTH + 1);
	localparam int CNT_W      = 13;
	localparam int CFG_W      = 44;
	localparam int CFG_IDX_W  = 1;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_INIT  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OOM   = 2'd1,
		ST_WRONG = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_KERN_BASE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USER_PAGES = 1'd1;

endpackage
`default_nettype wire

[rtl/trpfa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used for both free-page stacks.
`default_nettype none
module trpfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/two_region_page_frame_allocator_core.sv]
// Top level of the two-region page frame allocator: control, bounds checks
// and the two free-page stacks. Depends on trpfa_pkg and trpfa_ram.
//
// Usage:
// A command beat is taken at a rising edge where start is high and busy is
// low. command selects allocate, free or initialise; kern_sel picks the
// region; page_addr is the byte address for a free. Each command gives one
// result beat: done is high for exactly one cycle with result_addr, status
// and free_count valid in that cycle. The receiver cannot stall.
// For allocate, free and unused commands, the command executes in the cycle
// after the accepting edge, the result is shown in the cycle after that, and
// the next beat can be taken at the edge that ends the result cycle.
// The stack read for an allocate is launched at the accepting edge, so its
// registered data is ready when the command executes.
// Initialise writes one stack entry per cycle until the whole region is filled.
// Configuration writes go in through cfg_we/cfg_index/cfg_data and must only
// be made while busy is low and no result is pending.
// Reset empties both regions (counts to zero) and clears the configuration;
// the stack memories are not cleared, as only written entries are read.
`default_nettype none
module two_region_page_frame_allocator_core
	import trpfa_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           command,
	input  wire logic                 kern_sel,
	input  wire logic [ADDR_W-1:0]    page_addr,
	output logic                      done,
	output logic      [ADDR_W-1:0]    result_addr,
	output logic      [1:0]           status,
	output logic      [CNT_W-1:0]     free_count,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_INIT
	} state_t;

	state_t state_q;

	// Configuration, kept as the first frame of each region and the user region size.
	logic [FIRST_W-1:0] kern_first_q;
	logic [FIRST_W-1:0] user_first_q;
	logic [CNT_W-1:0]   user_pages_q;

	logic [KERN_CNT_W-1:0] kern_count_q;
	logic [CNT_W-1:0]      user_count_q;

	// Latched command beat.
	logic [1:0]        cmd_q;
	logic              kern_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  size_q;

	logic                  accept;
	logic [CNT_W-1:0]      user_size;
	logic [CNT_W-1:0]      sel_size;
	logic [CNT_W-1:0]      sel_count;
	logic                  sel_full;
	logic [FIRST_W-1:0]    sel_first;
	logic [USER_IDX_W-1:0] sel_offset;
	logic [FIRST_W-1:0]    alloc_frame;
	logic [DIFF_W-1:0]     diff;
	logic                  free_ok;
	logic                  free_push;
	logic                  init_write;
	logic                  init_last;

	logic                  kern_we;
	logic [KERN_IDX_W-1:0] kern_waddr;
	logic [KERN_IDX_W-1:0] kern_wdata;
	logic [KERN_IDX_W-1:0] kern_raddr;
	logic [KERN_IDX_W-1:0] kern_rdata;
	logic                  user_we;
	logic [USER_IDX_W-1:0] user_waddr;
	logic [USER_IDX_W-1:0] user_wdata;
	logic [USER_IDX_W-1:0] user_raddr;
	logic [USER_IDX_W-1:0] user_rdata;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		user_size = (user_pages_q > CNT_W'(USER_PAGES)) ? CNT_W'(USER_PAGES) : user_pages_q;
		sel_size  = kern_q ? CNT_W'(KERN_DEPTH) : user_size;
		sel_count = kern_q ? CNT_W'(kern_count_q) : user_count_q;
		sel_full  = kern_q ? (kern_count_q >= KERN_CNT_W'(KERN_DEPTH))
		                   : (user_count_q >= CNT_W'(USER_PAGES));
		sel_first  = kern_q ? kern_first_q : user_first_q;
		sel_offset = kern_q ? USER_IDX_W'(kern_rdata) : user_rdata;
		alloc_frame = sel_first + FIRST_W'(sel_offset);
		// A borrow out of the subtraction means the frame lies below the region.
		diff = {2'b00, addr_q[ADDR_W-1:PAGE_SHIFT]} - {1'b0, sel_first};
		free_ok = (addr_q[PAGE_SHIFT-1:0] == '0) && !diff[DIFF_W-1]
		          && (diff[FIRST_W-1:0] < FIRST_W'(sel_size));
		free_push  = (state_q == S_EXEC) && (cmd_q == CMD_FREE) && free_ok && !sel_full;
		init_last  = (idx_q == size_q);
		init_write = (state_q == S_INIT) && !init_last;
	end

	// The stack read for an allocate is issued at the accepting edge.
	assign kern_raddr = kern_count_q[KERN_IDX_W-1:0] - KERN_IDX_W'(1);
	assign user_raddr = user_count_q[USER_IDX_W-1:0] - USER_IDX_W'(1);

	always_comb begin
		kern_we    = kern_q && (free_push || init_write);
		user_we    = !kern_q && (free_push || init_write);
		kern_waddr = init_write ? idx_q[KERN_IDX_W-1:0] : kern_count_q[KERN_IDX_W-1:0];
		kern_wdata = init_write ? idx_q[KERN_IDX_W-1:0] : diff[KERN_IDX_W-1:0];
		user_waddr = init_write ? idx_q[USER_IDX_W-1:0] : user_count_q[USER_IDX_W-1:0];
		user_wdata = init_write ? idx_q[USER_IDX_W-1:0] : diff[USER_IDX_W-1:0];
	end

	trpfa_ram #(
		.WIDTH(KERN_IDX_W),
		.DEPTH(KERN_DEPTH)
	) u_kern_stack (
		.clk  (clk),
		.we   (kern_we),
		.waddr(kern_waddr),
		.wdata(kern_wdata),
		.re   (accept),
		.raddr(kern_raddr),
		.rdata(kern_rdata)
	);

	trpfa_ram #(
		.WIDTH(USER_IDX_W),
		.DEPTH(USER_PAGES)
	) u_user_stack (
		.clk  (clk),
		.we   (user_we),
		.waddr(user_waddr),
		.wdata(user_wdata),
		.re   (accept),
		.raddr(user_raddr),
		.rdata(user_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_first_q <= '0;
			user_first_q <= FIRST_W'(KERN_DEPTH);
			user_pages_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KERN_BASE: begin
					kern_first_q <= {1'b0, cfg_data};
					user_first_q <= {1'b0, cfg_data} + FIRST_W'(KERN_DEPTH);
				end
				CFG_USER_PAGES: begin
					user_pages_q <= cfg_data[CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Payload of the accepted beat; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			kern_q <= kern_sel;
			addr_q <= page_addr;
			size_q <= kern_sel ? CNT_W'(KERN_DEPTH) : user_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kern_count_q <= '0;
			user_count_q <= '0;
			idx_q        <= '0;
			done         <= 1'b0;
			result_addr  <= '0;
			status       <= ST_OK;
			free_count   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= (command == CMD_INIT) ? S_INIT : S_EXEC;
					end
				end
				S_EXEC: begin
					done        <= 1'b1;
					result_addr <= '0;
					status      <= ST_OK;
					free_count  <= sel_count;
					state_q     <= S_IDLE;
					case (cmd_q)
						CMD_ALLOC: begin
							if (sel_count == '0) begin
								status <= ST_OOM;
							end else begin
								result_addr <= {alloc_frame[FRAME_W-1:0], PAGE_SHIFT'(0)};
								free_count  <= sel_count - CNT_W'(1);
								if (kern_q) begin
									kern_count_q <= kern_count_q - KERN_CNT_W'(1);
								end else begin
									user_count_q <= user_count_q - CNT_W'(1);
								end
							end
						end
						CMD_FREE: begin
							if (!free_ok) begin
								status <= ST_WRONG;
							end else if (sel_full) begin
								status <= ST_FULL;
							end else begin
								free_count <= sel_count + CNT_W'(1);
								if (kern_q) begin
									kern_count_q <= kern_count_q + KERN_CNT_W'(1);
								end else begin
									user_count_q <= user_count_q + CNT_W'(1);
								end
							end
						end
						default: begin
						end
					endcase
				end
				S_INIT: begin
					if (init_last) begin
						done        <= 1'b1;
						result_addr <= '0;
						status      <= ST_OK;
						free_count  <= size_q;
						state_q     <= S_IDLE;
						if (kern_q) begin
							kern_count_q <= size_q[KERN_CNT_W-1:0];
						end else begin
							user_count_q <= size_q;
						end
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result beat lasts a single cycle, since the block is idle afterwards.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// The block only returns to idle together with a result beat.
	a_idle_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("block went idle without a result beat");

	a_kern_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kern_count_q <= KERN_CNT_W'(KERN_DEPTH))
		else $error("kernel free count exceeds stack depth");

	a_user_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		user_count_q <= CNT_W'(USER_PAGES))
		else $error("user free count exceeds stack depth");

	// An out-of-memory result never carries an address.
	a_oom_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_OOM)) |-> (result_addr == '0))
		else $error("address returned with out-of-memory status");

endmodule
`default_nettype wire

[dv/trpfa_checker.sv]
// Checker for the two-region page frame allocator: watches the command, result and
// register ports, predicts every result beat and compares it field by field.
// Depends on trpfa_pkg for widths, command and status codes and register indexes.
`timescale 1ns / 100ps
module trpfa_checker
	import trpfa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [1:0]           command,
	input  logic                 kern_sel,
	input  logic [ADDR_W-1:0]    page_addr,
	input  logic                 done,
	input  logic [ADDR_W-1:0]    result_addr,
	input  logic [1:0]           status,
	input  logic [CNT_W-1:0]     free_count,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   pending,
	output int                   checked
);

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [1:0]        st;
		logic [CNT_W-1:0]  cnt;
	} alloc_outcome_t;

	// Free stacks hold page offsets within their region, not frame numbers.
	logic [KERN_IDX_W-1:0] kern_stack [KERN_DEPTH];
	logic [USER_IDX_W-1:0] user_stack [USER_PAGES];
	logic [CNT_W-1:0]      kern_cnt;
	logic [CNT_W-1:0]      user_cnt;
	logic [CFG_W-1:0]      base_page;
	logic [CNT_W-1:0]      user_pages_cfg;
	alloc_outcome_t        outcome_q [$];
	int                    errors;
	int                    compared;

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		$display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
		errors++;
	endtask

	function automatic alloc_outcome_t apply_command(logic [1:0] cmd, logic kern,
			logic [ADDR_W-1:0] addr);
		alloc_outcome_t res;
		logic [63:0]    cnt;
		logic [63:0]    depth;
		logic [63:0]    region_start;
		logic [63:0]    region_size;
		logic [63:0]    first;
		logic [63:0]    frame;
		logic [63:0]    offset;
		int             i;
		res = '0;
		cnt = kern ? 64'(kern_cnt) : 64'(user_cnt);
		depth = kern ? 64'(KERN_DEPTH) : 64'(USER_PAGES);
		region_start = kern ? 64'(0) : 64'(KERN_DEPTH);
		region_size = kern ? 64'(KERN_DEPTH) :
			(user_pages_cfg > USER_PAGES ? 64'(USER_PAGES) : 64'(user_pages_cfg));
		case (cmd)
			CMD_ALLOC: begin
				if (cnt == 0) begin
					res.st = ST_OOM;
				end else begin
					cnt = cnt - 1;
					offset = kern ? 64'(kern_stack[cnt]) : 64'(user_stack[cnt]);
					frame = 64'(base_page) + region_start + offset;
					res.addr = ADDR_W'(frame << PAGE_SHIFT);
				end
			end
			CMD_FREE: begin
				first = 64'(base_page) + region_start;
				frame = 64'(addr >> PAGE_SHIFT);
				if (addr[PAGE_SHIFT-1:0] != 0 || frame < first || frame - first >= region_size) begin
					res.st = ST_WRONG;
				end else if (cnt >= depth) begin
					res.st = ST_FULL;
				end else begin
					if (kern)
						kern_stack[cnt] = KERN_IDX_W'(frame - first);
					else
						user_stack[cnt] = USER_IDX_W'(frame - first);
					cnt = cnt + 1;
				end
			end
			CMD_INIT: begin
				for (i = 0; i < region_size; i++) begin
					if (kern)
						kern_stack[i] = KERN_IDX_W'(i);
					else
						user_stack[i] = USER_IDX_W'(i);
				end
				cnt = region_size;
			end
			default: ;
		endcase
		if (kern)
			kern_cnt = CNT_W'(cnt);
		else
			user_cnt = CNT_W'(cnt);
		res.cnt = CNT_W'(cnt);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		alloc_outcome_t want;
		if (!arst_n) begin
			kern_cnt = '0;
			user_cnt = '0;
			base_page = '0;
			user_pages_cfg = '0;
			outcome_q.delete();
			errors = 0;
			compared = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_KERN_BASE)
					base_page = cfg_data;
				else
					user_pages_cfg = cfg_data[CNT_W-1:0];
			end
			// The result of the previous beat is compared before a beat taken at this edge is predicted.
			if (done) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("unexpected result beat (address)", 0, 64'(result_addr));
				end else begin
					want = outcome_q.pop_front();
					compared++;
					if (result_addr !== want.addr)
						report_mismatch("result_addr", 64'(want.addr), 64'(result_addr));
					if (status !== want.st)
						report_mismatch("status", 64'(want.st), 64'(status));
					if (free_count !== want.cnt)
						report_mismatch("free_count", 64'(want.cnt), 64'(free_count));
				end
			end
			if (start && !busy)
				outcome_q.push_back(apply_command(command, kern_sel, page_addr));
		end
		mismatches <= errors;
		pending <= outcome_q.size();
		checked <= compared;
	end

endmodule

[dv/tb_two_region_page_frame_allocator_core.sv]
// Testbench top for the two-region page frame allocator: clock, reset, register
// writes and command stimulus, directed then random. Depends on trpfa_pkg, the
// block itself and trpfa_checker, which does all prediction and comparison.
`timescale 1ns / 100ps
module tb_two_region_page_frame_allocator_core;
	import trpfa_pkg::*;

	localparam logic [1:0]       CMD_NONE        = 2'd3;
	localparam logic [CFG_W-1:0] BASE_MAX        = '1;
	localparam logic [CNT_W-1:0] UPAGES_MAX      = '1;
	localparam int               WATCHDOG_LIMIT  = 20000;
	localparam int               RANDOM_PHASES   = 8;
	localparam int               ITEMS_PER_PHASE = 50;
	localparam int               POOL_CAP        = 64;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [1:0]           command = '0;
	logic                 kern_sel = 1'b0;
	logic [ADDR_W-1:0]    page_addr = '0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 busy;
	logic                 done;
	logic [ADDR_W-1:0]    result_addr;
	logic [1:0]           status;
	logic [CNT_W-1:0]     free_count;
	int                   mismatches;
	int                   pending;
	int                   checked;

	logic [CFG_W-1:0]     base_cfg = '0;
	logic [CNT_W-1:0]     upages_cfg = '0;
	bit                   gaps_on;
	logic [ADDR_W-1:0]    kern_pool [$];
	logic [ADDR_W-1:0]    user_pool [$];
	bit                   issued_alloc [$];
	bit                   issued_kern [$];
	int                   sent = 0;
	int                   settings_used = 0;
	int                   idle_cycles = 0;
	int                   status_seen [4] = '{0, 0, 0, 0};

	always #5 clk = ~clk;

	two_region_page_frame_allocator_core dut (.*);

	trpfa_checker alloc_check (.*);

	// Sampled mid-cycle so that the pools of allocated pages never race the driver.
	always @(negedge clk) begin : pool_watch
		bit was_alloc;
		bit was_kern;
		if (done && issued_alloc.size() != 0) begin
			was_alloc = issued_alloc.pop_front();
			was_kern = issued_kern.pop_front();
			status_seen[status]++;
			if (was_alloc && status == ST_OK) begin
				if (was_kern && kern_pool.size() < POOL_CAP)
					kern_pool.push_back(result_addr);
				else if (!was_kern && user_pool.size() < POOL_CAP)
					user_pool.push_back(result_addr);
			end
		end
		if (start && !busy) begin
			issued_alloc.push_back(command == CMD_ALLOC);
			issued_kern.push_back(kern_sel);
		end
		if ((start && !busy) || done || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles, %0d results outstanding",
				idle_cycles, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic [ADDR_W-1:0] page_of(logic kern, logic [63:0] off);
		logic [63:0] frame;
		frame = 64'(base_cfg) + (kern ? 64'(0) : 64'(KERN_DEPTH)) + off;
		return ADDR_W'(frame << PAGE_SHIFT);
	endfunction

	// Returns at the edge that takes the beat; the caller drives the next beat or
	// lowers start in that same time step.
	task automatic send(logic [1:0] cmd, logic kern, logic [ADDR_W-1:0] addr);
		int gap;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		kern_sel <= kern;
		page_addr <= addr;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(logic [CFG_W-1:0] base, logic [CNT_W-1:0] upages);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_KERN_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= CFG_USER_PAGES;
		cfg_data <= CFG_W'(upages);
		@(posedge clk);
		cfg_we <= 1'b0;
		base_cfg = base;
		upages_cfg = upages;
		settings_used++;
		kern_pool.delete();
		user_pool.delete();
	endtask

	task automatic random_item();
		int                pick;
		int                idx;
		logic              kern;
		logic [63:0]       region_size;
		logic [63:0]       off;
		logic [ADDR_W-1:0] addr;
		pick = $urandom_range(0, 99);
		kern = 1'($urandom_range(0, 1));
		region_size = kern ? 64'(KERN_DEPTH) :
			(upages_cfg > USER_PAGES ? 64'(USER_PAGES) : 64'(upages_cfg));
		off = region_size == 0 ? 64'(0) : 64'($urandom_range(0, int'(region_size) - 1));
		if (pick < 40) begin
			send(CMD_ALLOC, kern, rand_addr());
		end else if (pick < 62) begin
			// Hand back a page that was allocated earlier in this setting, or any page of the region if none is held.
			addr = page_of(kern, off);
			if (kern && kern_pool.size() != 0) begin
				idx = $urandom_range(0, kern_pool.size() - 1);
				addr = kern_pool[idx];
				kern_pool.delete(idx);
			end else if (!kern && user_pool.size() != 0) begin
				idx = $urandom_range(0, user_pool.size() - 1);
				addr = user_pool[idx];
				user_pool.delete(idx);
			end
			send(CMD_FREE, kern, addr);
		end else if (pick < 77) begin
			send(CMD_FREE, kern, page_of(kern, off));
		end else if (pick < 85) begin
			case ($urandom_range(0, 3))
				0: addr = page_of(kern, '1);
				1: addr = page_of(kern, region_size);
				2: addr = page_of(kern, region_size - 1);
				default: addr = page_of(kern, off) | ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
			endcase
			send(CMD_FREE, kern, addr);
		end else if (pick < 92) begin
			send(CMD_FREE, kern, rand_addr());
		end else if (pick < 96) begin
			send(CMD_NONE, kern, rand_addr());
		end else begin
			send(CMD_INIT, kern, rand_addr());
		end
	endtask

	initial begin : stimulus
		int               phase_no;
		logic [CFG_W-1:0] base;
		logic [CNT_W-1:0] upages;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset settings: empty regions, zero user size.
		gaps_on = 1'b0;
		send(CMD_ALLOC, 1'b1, '1);
		send(CMD_ALLOC, 1'b0, '0);
		send(CMD_NONE, 1'b1, '1);
		send(CMD_FREE, 1'b1, '0);
		send(CMD_FREE, 1'b1, '1);
		send(CMD_ALLOC, 1'b1, '0);
		send(CMD_INIT, 1'b0, '0);
		send(CMD_FREE, 1'b0, page_of(1'b0, 0));
		send(CMD_INIT, 1'b1, '0);
		send(CMD_FREE, 1'b1, page_of(1'b1, 5));
		send(CMD_ALLOC, 1'b1, '0);
		send(CMD_FREE, 1'b1, page_of(1'b1, 1023));
		start <= 1'b0;

		// Top of the frame space: kernel pages now wrap past the address space and
		// the user size saturates.
		set_config(BASE_MAX, UPAGES_MAX);
		gaps_on = 1'b1;
		send(CMD_ALLOC, 1'b1, '0);
		send(CMD_FREE, 1'b1, page_of(1'b1, 1023));
		send(CMD_FREE, 1'b1, page_of(1'b1, 0));
		send(CMD_FREE, 1'b1, page_of(1'b1, 0));
		send(CMD_INIT, 1'b0, '0);
		send(CMD_ALLOC, 1'b0, '1);
		send(CMD_FREE, 1'b0, page_of(1'b0, 7) | ADDR_W'(PAGE_BYTES / 2));
		send(CMD_FREE, 1'b0, page_of(1'b1, 3));
		send(CMD_NONE, 1'b0, '0);
		send(CMD_FREE, 1'b0, {BASE_MAX, PAGE_SHIFT'(0)});
		start <= 1'b0;

		for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
			base = CFG_W'({$urandom(), $urandom()});
			case (phase_no)
				0: begin base = '0; upages = CNT_W'(USER_PAGES); end
				1: begin base = BASE_MAX; upages = UPAGES_MAX; end
				2: upages = CNT_W'($urandom_range(1, 64));
				3: upages = '0;
				4: upages = CNT_W'(1);
				5: begin base = BASE_MAX - CFG_W'(KERN_DEPTH + 8); upages = CNT_W'(64); end
				6: upages = CNT_W'($urandom_range(0, 8191));
				default: begin
					base = CFG_W'($urandom_range(0, 255));
					upages = CNT_W'($urandom_range(4000, USER_PAGES));
				end
			endcase
			set_config(base, upages);
			gaps_on = $urandom_range(0, 3) != 0;
			// Skipping the fill now and then leaves old offsets under the new bounds.
			if (phase_no == 0 || $urandom_range(0, 3) != 0) begin
				send(CMD_INIT, 1'b1, rand_addr());
				send(CMD_INIT, 1'b0, rand_addr());
			end
			repeat (ITEMS_PER_PHASE) random_item();
			start <= 1'b0;
		end

		wait_idle();
		repeat (6) @(posedge clk);
		$display("Summary: %0d commands under %0d register settings, %0d results checked.",
			sent, settings_used, checked);
		$display("Statuses seen: ok %0d, out of memory %0d, wrong page %0d, stack full %0d.",
			status_seen[ST_OK], status_seen[ST_OOM], status_seen[ST_WRONG], status_seen[ST_FULL]);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
